@@ rtl/cvd_pkg.sv @@
// Shared types, widths and the square root digit step for the cosine and distance block.
package cvd_pkg;

   localparam int SUM_W = 48;
   localparam int ROOT_W = 24;
   localparam int REM_W = ROOT_W + 2;
   localparam int COS_W = 16;
   localparam int DIST_W = 22;
   localparam int QUO_W = 16;
   localparam int NUM_W = SUM_W + 14;
   localparam int CNT_W = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int LEVEL_W = 3;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [QUO_W-1:0] COS_ONE = 16'd16384;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Four sums of one finished vector pair.
   typedef struct packed {
      logic signed [SUM_W-1:0] dot;
      logic [SUM_W-1:0] norm_a;
      logic [SUM_W-1:0] norm_b;
      logic [SUM_W-1:0] diff_sq;
   } sums_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } root_step_type;

   // One digit of a restoring integer square root, two radicand bits per step.
   function automatic root_step_type root_step(input logic [REM_W-1:0] rem,
                                               input logic [ROOT_W-1:0] root,
                                               input logic [1:0] pair);
      logic [REM_W+1:0] shifted;
      logic [REM_W+1:0] trial;
      root_step_type res;
      shifted = {rem, pair};
      trial = {2'b00, root, 2'b01};
      if (shifted >= trial) begin
         res.rem = REM_W'(shifted - trial);
         res.root = {root[ROOT_W-2:0], 1'b1};
      end else begin
         res.rem = REM_W'(shifted);
         res.root = {root[ROOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

@@ rtl/cvd_front.sv @@
// Front end: takes element pairs, squares and multiplies them, and accumulates the four sums.
module cvd_front
   import cvd_pkg::*;
#(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [ELEM_WIDTH-1:0]  a_elem,
   input  logic signed [ELEM_WIDTH-1:0]  b_elem,
   input  logic                          last_elem,
   input  logic [LEVEL_W-1:0]            queue_level,
   output logic                          push,
   output sums_type                      push_sums
);

   localparam int P_W = 2 * ELEM_WIDTH;
   localparam int DD_W = 2 * ELEM_WIDTH + 1;
   localparam int ADD_W = ((DD_W > SUM_W) ? DD_W : SUM_W) + 1;

   logic accept;
   logic s1_valid_ff, s1_last_ff;
   logic signed [ELEM_WIDTH-1:0] s1_a_ff, s1_b_ff;
   logic s2_valid_ff, s2_last_ff;
   logic signed [P_W-1:0] s2_ab_ff;
   logic [P_W-1:0] s2_aa_ff, s2_bb_ff;
   logic [DD_W-1:0] s2_dd_ff;
   sums_type acc_ff, acc_in, sums_new;
   logic signed [ELEM_WIDTH:0] diff;
   logic signed [2*ELEM_WIDTH+1:0] diff_sq_full;
   logic signed [SUM_W:0] dot_wide;
   logic [ADD_W-1:0] na_wide, nb_wide, dd_wide;
   logic [1:0] inflight;
   logic [LEVEL_W:0] needed;

   // Every last pair still in the pipe holds a queue slot, so the pipe never stalls.
   always_comb begin
      inflight = {1'b0, s1_valid_ff & s1_last_ff} + {1'b0, s2_valid_ff & s2_last_ff};
      needed = {1'b0, queue_level} + {2'b00, inflight} + (LEVEL_W+1)'(1);
      in_ready = (needed <= (LEVEL_W+1)'(QUEUE_DEPTH));
      accept = in_valid & in_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_a_ff <= a_elem;
      s1_b_ff <= b_elem;
      s1_last_ff <= last_elem;
      s2_last_ff <= s1_last_ff;
      s2_ab_ff <= s1_a_ff * s1_b_ff;
      s2_aa_ff <= P_W'(s1_a_ff * s1_a_ff);
      s2_bb_ff <= P_W'(s1_b_ff * s1_b_ff);
      s2_dd_ff <= DD_W'(diff_sq_full);
   end

   assign diff = {s1_a_ff[ELEM_WIDTH-1], s1_a_ff} - {s1_b_ff[ELEM_WIDTH-1], s1_b_ff};
   assign diff_sq_full = diff * diff;

   // Saturating accumulation.
   always_comb begin
      dot_wide = {acc_ff.dot[SUM_W-1], acc_ff.dot}
               + {{(SUM_W+1-P_W){s2_ab_ff[P_W-1]}}, s2_ab_ff};
      na_wide = {{(ADD_W-SUM_W){1'b0}}, acc_ff.norm_a} + {{(ADD_W-P_W){1'b0}}, s2_aa_ff};
      nb_wide = {{(ADD_W-SUM_W){1'b0}}, acc_ff.norm_b} + {{(ADD_W-P_W){1'b0}}, s2_bb_ff};
      dd_wide = {{(ADD_W-SUM_W){1'b0}}, acc_ff.diff_sq} + {{(ADD_W-DD_W){1'b0}}, s2_dd_ff};
      if (dot_wide[SUM_W] != dot_wide[SUM_W-1]) begin
         sums_new.dot = dot_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sums_new.dot = dot_wide[SUM_W-1:0];
      end
      sums_new.norm_a = (|na_wide[ADD_W-1:SUM_W]) ? SUM_MAX : na_wide[SUM_W-1:0];
      sums_new.norm_b = (|nb_wide[ADD_W-1:SUM_W]) ? SUM_MAX : nb_wide[SUM_W-1:0];
      sums_new.diff_sq = (|dd_wide[ADD_W-1:SUM_W]) ? SUM_MAX : dd_wide[SUM_W-1:0];
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_last_ff ? '0 : sums_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign push = s2_valid_ff & s2_last_ff;
   assign push_sums = sums_new;

endmodule

@@ rtl/cvd_queue.sv @@
// Short queue of finished sum sets between the front and back ends.
module cvd_queue
   import cvd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sums_type           push_sums,
   input  logic               pop,
   output sums_type           head,
   output logic               not_empty,
   output logic [LEVEL_W-1:0] level
);

   sums_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [LEVEL_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + LEVEL_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - LEVEL_W'(1);
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_sums;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign level = count_ff;

endmodule

@@ rtl/cvd_back.sv @@
// Back end: three square roots, the norm product, a restoring divide and the result register.
module cvd_back
   import cvd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     not_empty,
   input  sums_type                 head,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [COS_W-1:0]  cosine,
   output logic [DIST_W-1:0]        distance,
   output logic                     zero_norm
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ROOT = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] rad_ff [3];
   logic [REM_W-1:0] rem_ff [3];
   logic [ROOT_W-1:0] root_ff [3];
   root_step_type step [3];
   logic signed [SUM_W-1:0] dot_ff;
   logic [2*ROOT_W-1:0] den_ff;
   logic [NUM_W-1:0] num_ff;
   logic [SUM_W-1:0] drem_ff;
   logic [SUM_W:0] drem_sh;
   logic div_ge;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W:0] quo_next;
   logic sat_ff, neg_ff, zero_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [SUM_W-1:0] mag;
   logic [QUO_W-1:0] cos_mag;
   logic out_valid_ff;
   logic signed [COS_W-1:0] out_cos_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic out_zero_ff;
   logic load_out;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         step[i] = root_step(rem_ff[i], root_ff[i], rad_ff[i][SUM_W-1:SUM_W-2]);
      end
      drem_sh = {drem_ff, num_ff[NUM_W-1]};
      div_ge = (drem_sh >= {1'b0, den_ff});
      quo_next = {quo_ff, div_ge};
      mag = dot_ff[SUM_W-1] ? SUM_W'(-dot_ff) : dot_ff;
      cos_mag = sat_ff ? COS_ONE : quo_ff;
   end

   assign pop = (state_ff == ST_IDLE) && not_empty;
   assign load_out = (state_ff == ST_DONE) && (!out_valid_ff || out_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (not_empty) state_in = ST_ROOT;
         ST_ROOT: if (cnt_ff == CNT_W'(ROOT_W - 1)) state_in = ST_MUL;
         ST_MUL: begin
            state_in = ((root_ff[0] == '0) || (root_ff[1] == '0)) ? ST_DONE : ST_DIV;
         end
         ST_DIV: if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            cnt_ff <= '0;
            dot_ff <= head.dot;
            rad_ff[0] <= head.norm_a;
            rad_ff[1] <= head.norm_b;
            rad_ff[2] <= head.diff_sq;
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= '0;
               root_ff[i] <= '0;
            end
         end
         ST_ROOT: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= step[i].rem;
               root_ff[i] <= step[i].root;
               rad_ff[i] <= {rad_ff[i][SUM_W-3:0], 2'b00};
            end
         end
         ST_MUL: begin
            cnt_ff <= '0;
            den_ff <= root_ff[0] * root_ff[1];
            zero_ff <= (root_ff[0] == '0) || (root_ff[1] == '0);
            dist_ff <= (|root_ff[2][ROOT_W-1:DIST_W]) ? DIST_MAX : root_ff[2][DIST_W-1:0];
            neg_ff <= dot_ff[SUM_W-1];
            num_ff <= {mag, 14'd0};
            drem_ff <= '0;
            quo_ff <= '0;
            sat_ff <= 1'b0;
         end
         ST_DIV: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            drem_ff <= div_ge ? SUM_W'(drem_sh - {1'b0, den_ff}) : drem_sh[SUM_W-1:0];
            quo_ff <= quo_next[QUO_W-1:0];
            if (quo_next > {1'b0, COS_ONE}) begin
               sat_ff <= 1'b1;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               out_zero_ff <= zero_ff;
               out_dist_ff <= dist_ff;
               if (zero_ff) begin
                  out_cos_ff <= '0;
               end else begin
                  out_cos_ff <= neg_ff ? -$signed(cos_mag) : $signed(cos_mag);
               end
            end
         end
         default: cnt_ff <= '0;
      endcase
   end

   assign out_valid = out_valid_ff;
   assign cosine = out_cos_ff;
   assign distance = out_dist_ff;
   assign zero_norm = out_zero_ff;

endmodule

@@ rtl/vector_cosine_and_distance.sv @@
// Top level of the streaming cosine similarity and Euclidean distance block.
//
// Element pairs of two vectors arrive on the req_ channel, one word per
// cycle while req_tready is high. Each word carries a and b in signed Q3.12 and tlast
// marks the final pair. The front end registers each pair, multiplies in a
// second registered stage and
// accumulates dot product, both squared norms and squared difference. When
// the last pair is summed, the four sums go into a four-entry queue and the
// accumulators clear, so the next vector starts at once.
// The back end takes one sum set at a time: the three floor square roots
// (one digit per cycle, three lanes), the norm product, then the restoring
// divide of dot*2^14 by that product, one quotient bit per cycle. The divide
// is skipped when a norm root is zero. Short vectors that arrive faster than
// the back end finishes sum sets fill the queue, and req_tready then drops
// until the back end frees a slot.
// One result word per vector leaves on rsp_; it holds in its register while
// rsp_tready is low, and the back end waits with the next result.
// Reset clears all sums, the queue and all valid flags.
module vector_cosine_and_distance
   import cvd_pkg::*;
#(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // a_element, b_element, then zero padding
   input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // cosine, distance, then zero padding
   output logic [39:0]                           rsp_tdata,
   // zero_norm
   output logic                                  rsp_tuser
);

   logic push, pop, not_empty;
   sums_type push_sums, head;
   logic [LEVEL_W-1:0] level;
   logic signed [COS_W-1:0] cosine;
   logic [DIST_W-1:0] distance;

   cvd_front #(.ELEM_WIDTH(ELEM_WIDTH)) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .a_elem(req_tdata[ELEM_WIDTH-1:0]),
      .b_elem(req_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
      .last_elem(req_tlast),
      .queue_level(level),
      .push(push),
      .push_sums(push_sums)
   );

   cvd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_sums(push_sums),
      .pop(pop),
      .head(head),
      .not_empty(not_empty),
      .level(level)
   );

   cvd_back u_back (
      .clock(clock),
      .reset(reset),
      .not_empty(not_empty),
      .head(head),
      .pop(pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .cosine(cosine),
      .distance(distance),
      .zero_norm(rsp_tuser)
   );

   assign rsp_tdata = {2'b00, distance, cosine};

endmodule

@@ verif/vector_cosine_and_distance_checker.sv @@
// Checker that predicts cosine and distance results and compares them with the block's output.
module vector_cosine_and_distance_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          mismatches,
   output int          pending
);

   typedef struct packed {
      logic signed [15:0] cosine;
      logic [21:0]        distance;
      logic               zero_norm;
   } result_type;

   localparam logic signed [47:0] DOT_HI = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] DOT_LO = {1'b1, {47{1'b0}}};
   localparam logic [47:0] NORM_HI = {48{1'b1}};

   logic signed [47:0] dot_acc;
   logic [47:0] norm_a_acc, norm_b_acc, diff_acc;
   result_type expected_results[$];

   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n = n - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic logic [47:0] sat_add(input logic [47:0] s, input logic [63:0] x);
      logic [63:0] r;
      r = {16'd0, s} + x;
      return (r > {16'd0, NORM_HI}) ? NORM_HI : r[47:0];
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("result %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      logic signed [63:0] a, b, d, nd;
      logic [63:0] ra, rb, dist_root, mag, q;
      result_type r, e;
      if (reset) begin
         dot_acc <= '0;
         norm_a_acc <= '0;
         norm_b_acc <= '0;
         diff_acc <= '0;
         mismatches = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            a = 64'(signed'(req_tdata[15:0]));
            b = 64'(signed'(req_tdata[31:16]));
            d = a - b;
            nd = 64'(dot_acc) + a * b;
            if (nd > 64'(DOT_HI)) nd = 64'(DOT_HI);
            if (nd < 64'(DOT_LO)) nd = 64'(DOT_LO);
            if (req_tlast) begin
               ra = isqrt({16'd0, sat_add(norm_a_acc, a * a)});
               rb = isqrt({16'd0, sat_add(norm_b_acc, b * b)});
               dist_root = isqrt({16'd0, sat_add(diff_acc, d * d)});
               if (dist_root > 64'h3fffff) dist_root = 64'h3fffff;
               r.distance = dist_root[21:0];
               if (ra == 0 || rb == 0) begin
                  r.zero_norm = 1'b1;
                  r.cosine = '0;
               end else begin
                  mag = (nd < 0) ? -nd : nd;
                  q = (mag << 14) / (ra * rb);
                  if (q > 16384) q = 16384;
                  r.zero_norm = 1'b0;
                  r.cosine = (nd < 0) ? -q[15:0] : q[15:0];
               end
               expected_results = {expected_results, r};
               dot_acc <= '0;
               norm_a_acc <= '0;
               norm_b_acc <= '0;
               diff_acc <= '0;
            end else begin
               dot_acc <= nd[47:0];
               norm_a_acc <= sat_add(norm_a_acc, a * a);
               norm_b_acc <= sat_add(norm_b_acc, b * b);
               diff_acc <= sat_add(diff_acc, d * d);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("result word with no expectation waiting");
               mismatches++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_tdata[15:0] !== e.cosine)
                  report("cosine", signed'(rsp_tdata[15:0]), e.cosine);
               if (rsp_tdata[37:16] !== e.distance)
                  report("distance", rsp_tdata[37:16], e.distance);
               if (rsp_tuser !== e.zero_norm)
                  report("zero_norm", rsp_tuser, e.zero_norm);
            end
         end
      end
   end

   assign pending = expected_results.size();

endmodule

@@ verif/vector_cosine_and_distance_test.sv @@
// Testbench top: drives element pairs into the block and gives the verdict.
module vector_cosine_and_distance_test;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // a_element, b_element
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // cosine, distance, then zero padding
   logic [39:0] rsp_tdata;
   // zero_norm
   logic        rsp_tuser;
   int          mismatches;
   int          pending;
   int          cycles;
   bit          calm;

   localparam int CYCLE_LIMIT = 900000;

   vector_cosine_and_distance uut (.*);

   vector_cosine_and_distance_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Cycle counter; a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // The receiver stalls in random bursts until the calm tail of the run.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (!calm) begin
            gap = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Send one word and hold it until the handshake completes.
   task automatic send_word(input logic [15:0] a, input logic [15:0] b, input logic last);
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Elements are mostly random over the full range, sometimes small or at the extremes of the range.
   function automatic logic [15:0] pick_element();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 8191)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_vector(input int length, input int kind);
      logic [15:0] a, b;
      for (int i = 0; i < length; i++) begin
         a = pick_element();
         b = pick_element();
         // Kinds cover equal, opposite and zero vectors beside random ones.
         case (kind)
            1: b = a;
            2: b = -a;
            3: a = '0;
            4: b = '0;
            default: ;
         endcase
         send_word(a, b, i == length - 1);
      end
   endtask

   initial begin
      int sent;
      int length;
      cycles = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed vectors: extremes, zero norms, parallel and opposite pairs.
      send_word(16'h8000, 16'h8000, 1'b1);
      send_word(16'h7fff, 16'h8000, 1'b1);
      send_word(16'h8000, 16'h7fff, 1'b1);
      send_word(16'h0000, 16'h0000, 1'b1);
      send_word(16'h0000, 16'h1234, 1'b1);
      send_word(16'h0001, 16'h0001, 1'b1);
      send_word(16'hffff, 16'h0001, 1'b1);
      // Floor roots push this one past one, so the cosine clamps.
      send_word(16'h0001, 16'h0001, 1'b0);
      send_word(16'h0001, 16'h0001, 1'b1);
      send_word(16'h0003, 16'h0003, 1'b1);
      send_vector(4, 1);
      send_vector(4, 2);
      send_vector(3, 3);
      send_vector(3, 4);

      // Hold off until the block has delivered everything so far.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      sent = 25;
      while (sent < 1650) begin
         if (sent > 1450) calm = 1'b1;
         length = ($urandom_range(0, 30) == 0) ? 1024 : $urandom_range(1, 12);
         if (length == 1024 && sent > 600) length = 8;
         send_vector(length, $urandom_range(0, 9));
         sent += length;
      end
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
